/* hdl/lru_key_value_cache_top_assert.svh */
// Assertion macros for the LRU key-value cache.
`ifndef LRU_KEY_VALUE_CACHE_TOP_ASSERT_SVH
`define LRU_KEY_VALUE_CACHE_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LKV_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LKV_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/lkv_pkg.sv */
// ----------------------------------------------------------------------------
// lkv_pkg
// Shared constants and controller/datapath interface types for the
// LRU key-value cache.
// ----------------------------------------------------------------------------
package lkv_pkg;

	localparam int ENTRIES_DEF = 16;
	localparam int KEY_W       = 32;
	localparam int VAL_W       = 32;
	localparam int CAP_W       = 5;

	localparam logic [CAP_W-1:0] CAP_RESET  = 5'd16;
	localparam logic             OP_GET     = 1'b0;
	localparam logic             OP_PUT     = 1'b1;
	localparam logic [VAL_W-1:0] MISS_VALUE = '1;

	// controller -> datapath
	typedef struct packed {
		logic load;    // capture request, clear scan trackers
		logic scan;    // read one entry and advance the scan index
		logic commit;  // apply update and register the result
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic scan_last;
	} dp_stat_t;

endpackage

/* hdl/lru_key_value_cache_top.sv */
// ----------------------------------------------------------------------------
// lru_key_value_cache_top
// Fully associative key-value cache with least-recently-used replacement.
//
//   channel   handshake        payload
//   request   start / busy     operation, lookup_key, write_value
//   result    done (strobe)    found, read_value
//   config    cfg_we           cfg_wdata (active capacity)
//
// A request is taken when start is high and busy is low. The entries are
// scanned one per cycle through the single read port of the entry store,
// so busy stays high through the scan, drain and commit states, and the
// result strobe rises in the same cycle that busy drops; a new request
// can be taken then. Reset clears valid marks, ranks and occupancy at once;
// no clearing pass. The result is shown for one cycle and cannot be stalled.
// ----------------------------------------------------------------------------
module lru_key_value_cache_top
	import lkv_pkg::*;
#(
	parameter int ENTRIES = ENTRIES_DEF
)
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  logic             operation,
	input  logic [KEY_W-1:0] lookup_key,
	input  logic [VAL_W-1:0] write_value,
	input  logic             cfg_we,
	input  logic [CAP_W-1:0] cfg_wdata,
	output logic             done,
	output logic             found,
	output logic [VAL_W-1:0] read_value
);

	`include "lru_key_value_cache_top_assert.svh"

	dp_cmd_t  cmd;
	dp_stat_t stat;

	lkv_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.stat   (stat),
		.cmd    (cmd)
	);

	lkv_dp #(
		.ENTRIES (ENTRIES)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.operation   (operation),
		.lookup_key  (lookup_key),
		.write_value (write_value),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.done        (done),
		.found       (found),
		.read_value  (read_value)
	);

	`LKV_ASSERT_NEXT(a_accept_busy, clk, arst_n, start && !busy, busy, "busy not raised after request")
	`LKV_ASSERT_NEXT(a_commit_done, clk, arst_n, cmd.commit, done, "no result after commit")
	`LKV_ASSERT_NOW(a_done_idle, clk, arst_n, done, !busy, "result strobe while busy")
	`LKV_ASSERT_NOW(a_one_cmd, clk, arst_n, cmd.scan, !cmd.commit && !cmd.load, "overlapping commands")

endmodule

/* hdl/lkv_ctrl.sv */
// ----------------------------------------------------------------------------
// lkv_ctrl
// Sequencer: scan all entries, wait for the last compare, then commit.
// ----------------------------------------------------------------------------
module lkv_ctrl
	import lkv_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_SCAN   = 2'd1;
	localparam logic [1:0] S_DRAIN  = 2'd2;
	localparam logic [1:0] S_COMMIT = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_nxt;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE:   if (start) state_nxt = S_SCAN;
			S_SCAN:   if (stat.scan_last) state_nxt = S_DRAIN;
			S_DRAIN:  state_nxt = S_COMMIT;
			S_COMMIT: state_nxt = S_IDLE;
			default:  state_nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	assign busy       = (state_q != S_IDLE);
	assign cmd.load   = (state_q == S_IDLE) && start;
	assign cmd.scan   = (state_q == S_SCAN);
	assign cmd.commit = (state_q == S_COMMIT);

endmodule

/* hdl/lkv_dp.sv */
// ----------------------------------------------------------------------------
// lkv_dp
// Entry store, recency ranks, scan trackers, update logic and result register.
// ----------------------------------------------------------------------------
module lkv_dp
	import lkv_pkg::*;
#(
	parameter int ENTRIES = ENTRIES_DEF
)
(
	input  logic             clk,
	input  logic             arst_n,
	input  dp_cmd_t          cmd,
	output dp_stat_t         stat,
	input  logic             operation,
	input  logic [KEY_W-1:0] lookup_key,
	input  logic [VAL_W-1:0] write_value,
	input  logic             cfg_we,
	input  logic [CAP_W-1:0] cfg_wdata,
	output logic             done,
	output logic             found,
	output logic [VAL_W-1:0] read_value
);

	localparam int IW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int OW   = $clog2(ENTRIES + 1);
	localparam int CMPW = (OW > CAP_W) ? OW : CAP_W;
	localparam int DW   = KEY_W + VAL_W;

	// request
	logic             op_q;
	logic [KEY_W-1:0] key_q;
	logic [VAL_W-1:0] wval_q;
	logic [CAP_W-1:0] cap_q;

	// state
	logic [DW-1:0]    mem [ENTRIES];
	logic [ENTRIES-1:0] valid_q;
	logic [IW-1:0]    rank_q [ENTRIES];
	logic [OW-1:0]    occ_q;

	// scan
	logic [IW-1:0]    scan_idx_q;
	logic             rd_en_s1;
	logic [IW-1:0]    idx_s1;
	logic [DW-1:0]    rd_s1;

	// trackers
	logic             hit_q;
	logic [IW-1:0]    hit_idx_q;
	logic [VAL_W-1:0] hit_val_q;
	logic [IW-1:0]    hit_rank_q;
	logic             free_any_q;
	logic [IW-1:0]    free_idx_q;
	logic             vic_any_q;
	logic [IW-1:0]    vic_idx_q;
	logic [IW-1:0]    vic_rank_q;

	// result
	logic             done_q;
	logic             found_q;
	logic [VAL_W-1:0] value_q;

	// commit decode
	logic             full;
	logic             fill;
	logic             do_touch;
	logic             mem_we;
	logic [IW-1:0]    tgt_idx;
	logic [IW-1:0]    old_rank;
	logic             e_valid;
	logic [IW-1:0]    e_rank;
	logic [KEY_W-1:0] e_key;

	assign stat.scan_last = (scan_idx_q == IW'(ENTRIES - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_we) begin
			cap_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= operation;
			key_q  <= lookup_key;
			wval_q <= write_value;
		end
	end

	// entry store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[tgt_idx] <= {key_q, wval_q};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan) begin
			rd_s1 <= mem[scan_idx_q];
		end
		idx_s1 <= scan_idx_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_idx_q <= '0;
			rd_en_s1   <= 1'b0;
		end else begin
			rd_en_s1 <= cmd.scan;
			if (cmd.load) begin
				scan_idx_q <= '0;
			end else if (cmd.scan) begin
				scan_idx_q <= scan_idx_q + 1'b1;
			end
		end
	end

	assign e_valid = valid_q[idx_s1];
	assign e_rank  = rank_q[idx_s1];
	assign e_key   = rd_s1[DW-1:VAL_W];

	// first hit, first free slot, and highest-ranked valid entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q      <= 1'b0;
			free_any_q <= 1'b0;
			vic_any_q  <= 1'b0;
		end else if (cmd.load) begin
			hit_q      <= 1'b0;
			free_any_q <= 1'b0;
			vic_any_q  <= 1'b0;
		end else if (rd_en_s1) begin
			if (e_valid && (e_key == key_q) && !hit_q) begin
				hit_q <= 1'b1;
			end
			if (!e_valid && !free_any_q) begin
				free_any_q <= 1'b1;
			end
			if (e_valid) begin
				vic_any_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en_s1) begin
			if (e_valid && (e_key == key_q) && !hit_q) begin
				hit_idx_q  <= idx_s1;
				hit_val_q  <= rd_s1[VAL_W-1:0];
				hit_rank_q <= e_rank;
			end
			if (!e_valid && !free_any_q) begin
				free_idx_q <= idx_s1;
			end
			if (e_valid && (!vic_any_q || (e_rank > vic_rank_q))) begin
				vic_idx_q  <= idx_s1;
				vic_rank_q <= e_rank;
			end
		end
	end

	// capacity of zero acts as one; above the entry count acts as the entry count
	always_comb begin
		if (cap_q == '0) begin
			full = (occ_q != '0);
		end else begin
			full = (CMPW'(occ_q) >= CMPW'(cap_q)) || (occ_q == OW'(ENTRIES));
		end
	end

	assign fill     = (op_q == OP_PUT) && !hit_q && !full && free_any_q;
	assign do_touch = hit_q || ((op_q == OP_PUT) && (full ? vic_any_q : free_any_q));
	assign mem_we   = cmd.commit && (op_q == OP_PUT) && do_touch;
	assign tgt_idx  = hit_q ? hit_idx_q : (full ? vic_idx_q : free_idx_q);
	assign old_rank = hit_q ? hit_rank_q : vic_rank_q;

	// per-entry rank lanes; a fresh fill ages every valid entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ENTRIES; i++) begin
				rank_q[i] <= '0;
			end
		end else if (cmd.commit && do_touch) begin
			for (int i = 0; i < ENTRIES; i++) begin
				if (IW'(i) == tgt_idx) begin
					rank_q[i] <= '0;
				end else if (valid_q[i] && (fill || (rank_q[i] < old_rank))) begin
					rank_q[i] <= rank_q[i] + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			occ_q   <= '0;
		end else if (cmd.commit && fill) begin
			valid_q[free_idx_q] <= 1'b1;
			occ_q               <= occ_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.commit;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			found_q <= hit_q;
			if (op_q == OP_PUT) begin
				value_q <= wval_q;
			end else begin
				value_q <= hit_q ? hit_val_q : MISS_VALUE;
			end
		end
	end

	assign done       = done_q;
	assign found      = found_q;
	assign read_value = value_q;

endmodule
